// ----- hw/rtl/lfod_pkg.sv -----
package lfod_pkg;

	// Byte value that closes a line
	localparam logic [7:0] NEWLINE = 8'd10;

	// Read request from the sequencer to the line memory
	typedef struct packed {
		logic en;    // issue a read this cycle
		logic last;  // this read fetches the newline of the line
	} rd_req_t;

endpackage

// ----- hw/rtl/lfod_line_ram.sv -----
module lfod_line_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// Single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port: data appears in the cycle after re
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/lfod_ctrl.sv -----
module lfod_ctrl #(
	parameter int CAPACITY = 64,
	parameter int ADDR_W   = 6,
	parameter int FILL_W   = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  logic              slot_free,
	output logic              we,
	output logic [ADDR_W-1:0] waddr,
	output logic [7:0]        wdata,
	output lfod_pkg::rd_req_t rd_req,
	output logic [ADDR_W-1:0] raddr,
	output logic [31:0]       tally
);
	import lfod_pkg::*;

	localparam logic ST_COLLECT = 1'b0;
	localparam logic ST_READ    = 1'b1;

	logic              state_q;
	logic [FILL_W-1:0] fill_q;
	logic              disc_q;
	logic [31:0]       tally_q;
	logic [ADDR_W-1:0] rd_idx_q;
	logic [ADDR_W-1:0] rd_end_q;

	logic accept;
	logic is_nl;
	logic full;

	assign in_ready = (state_q == ST_COLLECT);
	assign accept   = in_valid && in_ready;
	assign is_nl    = (rx_byte == NEWLINE);
	assign full     = (fill_q == FILL_W'(CAPACITY));

	// Store the beat at the current fill position
	assign we    = accept && !disc_q && !full;
	assign waddr = fill_q[ADDR_W-1:0];
	assign wdata = rx_byte;

	// Readout: one memory read per free output slot
	always_comb begin
		rd_req.en   = (state_q == ST_READ) && slot_free;
		rd_req.last = (rd_idx_q == rd_end_q);
	end
	assign raddr = rd_idx_q;
	assign tally = tally_q;

	// Fill, drop mode, lost-line count and readout sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_COLLECT;
			fill_q   <= '0;
			disc_q   <= 1'b0;
			tally_q  <= '0;
			rd_idx_q <= '0;
			rd_end_q <= '0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						if (disc_q) begin
							if (is_nl) begin
								disc_q <= 1'b0;
								fill_q <= '0;
							end
						end else if (full) begin
							disc_q  <= 1'b1;
							fill_q  <= '0;
							tally_q <= tally_q + 32'd1;
						end else if (is_nl) begin
							state_q  <= ST_READ;
							rd_idx_q <= '0;
							rd_end_q <= fill_q[ADDR_W-1:0];
							fill_q   <= '0;
						end else begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end
				end
				ST_READ: begin
					if (rd_req.en) begin
						if (rd_req.last) begin
							state_q <= ST_COLLECT;
						end else begin
							rd_idx_q <= rd_idx_q + ADDR_W'(1);
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

endmodule

// ----- hw/rtl/line_framer_overflow_drop.sv -----
// Newline-delimited line framer. Bytes are taken one per cycle on the input
// channel and stored in a line memory of LINE_CAPACITY entries. A newline
// ends the line: the whole line, newline included, then leaves on the output
// channel with line_last set on the newline. While a line is read out the
// input is held off; each output beat takes one memory read and then one
// output register load, and no new read is issued while one is in flight.
// A byte that finds the memory full is dropped, bumps lost_lines (wraps
// at 32 bits) and starts drop mode; bytes are then ignored up to and
// including the next newline. A newline dropped on overflow does not end drop
// mode, so the following line is lost as well. lost_lines is carried on every
// output beat.
module line_framer_overflow_drop #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  line_byte,
	output logic        line_last,
	output logic [31:0] lost_lines
);
	import lfod_pkg::*;

	localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
	localparam int FILL_W = $clog2(LINE_CAPACITY + 1);

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	rd_req_t           rd_req;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       tally;
	logic [7:0]        rdata;
	logic              slot_free;

	logic        pend_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic [7:0]  line_byte_q;
	logic        line_last_q;
	logic [31:0] lost_lines_q;

	lfod_ctrl #(
		.CAPACITY (LINE_CAPACITY),
		.ADDR_W   (ADDR_W),
		.FILL_W   (FILL_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.slot_free (slot_free),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.rd_req    (rd_req),
		.raddr     (raddr),
		.tally     (tally)
	);

	lfod_line_ram #(
		.DEPTH  (LINE_CAPACITY),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_req.en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// A read may go out only if the output register is free when data lands
	assign slot_free = !pend_s1 && (!out_valid_q || out_ready);

	// Read-in-flight stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_req.en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			last_s1 <= rd_req.last;
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			line_byte_q  <= rdata;
			line_last_q  <= last_s1;
			lost_lines_q <= tally;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_byte  = line_byte_q;
	assign line_last  = line_last_q;
	assign lost_lines = lost_lines_q;

endmodule
